// ===== hw/rtl/ipdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipdc_pkg: shared definitions of the incremental PID duty controller
// Field widths, register indexes, reset values and the layout of one
// channel's state word.
// ----------------------------------------------------------------------------
`default_nettype none

package ipdc_pkg;

  // Defaults of the top-level parameters.
  localparam int CHANNELS_DEF       = 2;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Field widths.
  localparam int SPEED_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int DUTY_W      = 15;
  localparam int ERR_W       = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEG = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DUTY_MAX   = 4'd3;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 16'sd2560;
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 16'sd512;
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 16'sd51;
  localparam logic [DUTY_W-1:0]        DUTY_MAX_RST   = 15'd100;

  // One channel's kept state as stored in the state memory.
  typedef struct packed {
    logic signed [ERR_W-1:0] err_last;
    logic signed [ERR_W-1:0] err_prev;
    logic [DUTY_W-1:0]       duty;
  } state_word_t;

endpackage : ipdc_pkg

`default_nettype wire

// ===== hw/rtl/ipdc_ram.sv =====
// ----------------------------------------------------------------------------
// ipdc_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address. A read of an address written at
// the same edge returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ipdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : ipdc_ram

`default_nettype wire

// ===== hw/rtl/incremental_pid_duty_controller_top.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_duty_controller_top: velocity-form PID for motor channels
// Each transaction on the input channel names a motor channel and brings a
// target and a measured speed. The block forms the saturated error, weighs
// it with the channel's two previous errors by the shared Q8.8 gains, adds
// the correction to the channel's kept duty, clamps it to 0..duty_max and
// returns one transaction with the channel and its new duty.
//
// Channels: input (in_valid/in_ready), output (out_valid/out_ready) and a
// configuration write channel (cfg_valid/cfg_ready, always ready) that sets
// gain_prop, gain_integ, gain_deriv and duty_max by index 0 to 3.
// Throughput: one transaction per cycle while out_ready stays high. An item
// passes the input stage, multiply stage and accumulate stage in that order,
// then the output register. The state of all channels lives in one small
// RAM with registered read; an item that follows an item of the same
// channel takes its history from the pipeline by forwarding.
// Reset: registers return to their reset values and every channel's
// history and duty read as zero, at once, without a clearing pass.
// Stall: while out_ready is low the output register holds; the stages
// behind it fill up and in_ready falls only when all of them are full.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_duty_controller_top #(
  parameter int CHANNELS       = ipdc_pkg::CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = ipdc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Input channel
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   channel,
  input  wire logic signed [ipdc_pkg::SPEED_W-1:0]    target_speed,
  input  wire logic signed [ipdc_pkg::SPEED_W-1:0]    measured_speed,
  // Output channel
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_channel,
  output logic             [ipdc_pkg::DUTY_W-1:0]     duty,
  // Configuration channel
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [ipdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [ipdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ipdc_pkg::*;

  localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUMW = 36;
  localparam logic signed [SUMW-1:0] RND_BIAS = SUMW'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_prop;
  logic signed [GAIN_W-1:0] gain_integ;
  logic signed [GAIN_W-1:0] gain_deriv;
  logic [DUTY_W-1:0]        duty_max;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= GAIN_PROP_RST;
      gain_integ <= GAIN_INTEG_RST;
      gain_deriv <= GAIN_DERIV_RST;
      duty_max   <= DUTY_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_PROP:  gain_prop  <= cfg_data;
        REG_GAIN_INTEG: gain_integ <= cfg_data;
        REG_GAIN_DERIV: gain_deriv <= cfg_data;
        REG_DUTY_MAX:   duty_max   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid;
  logic out_adv, s2_adv, s1_adv;
  logic in_acc;

  assign out_adv  = !out_valid || out_ready;
  assign s2_adv   = !s2_valid || out_adv;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_ready = s1_adv;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Input stage: saturated error and state read
  // --------------------------------------------------------------------------
  logic signed [ERR_W:0]   err_diff;
  logic signed [ERR_W-1:0] err_sat;
  logic                    in_ok;

  assign err_diff = {target_speed[SPEED_W-1], target_speed}
                  - {measured_speed[SPEED_W-1], measured_speed};
  assign in_ok    = (CHANNELS > 1) || (channel == 1'b0);

  // Saturate the error on overflow of the 16-bit range.
  always_comb begin
    if (err_diff[ERR_W] != err_diff[ERR_W-1]) begin
      err_sat = err_diff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err_sat = err_diff[ERR_W-1:0];
    end
  end

  logic                    s1_chan, s1_ok;
  logic signed [ERR_W-1:0] s1_err;
  logic [AW-1:0]           s1_addr;

  assign s1_addr = s1_ok ? AW'(s1_chan) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chan <= channel;
      s1_ok   <= in_ok;
      s1_err  <= err_sat;
    end
  end

  // --------------------------------------------------------------------------
  // State memory with per-channel valid bits
  // --------------------------------------------------------------------------
  logic [CHANNELS-1:0] entry_valid;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                wr_en;
  state_word_t         rd_word, wr_word;
  logic                rd_vld;

  // The address follows the item in the input stage, so a stalled item
  // keeps seeing writes made while it waits.
  assign rd_addr = in_acc ? (in_ok ? AW'(channel) : '0) : s1_addr;

  ipdc_ram #(
    .WIDTH ($bits(state_word_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= entry_valid[rd_addr];
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Write-back record of the most recent state write
  // --------------------------------------------------------------------------
  logic                    wb_valid, wb_chan;
  logic signed [ERR_W-1:0] wb_err, wb_err1;
  logic [DUTY_W-1:0]       wb_duty;

  // --------------------------------------------------------------------------
  // Multiply stage: forwarded history and the three products
  // --------------------------------------------------------------------------
  logic                    s2_chan, s2_ok;
  logic signed [ERR_W-1:0] s2_err, s2_err1;
  logic [DUTY_W-1:0]       s2_duty;
  logic signed [32:0]      s2_pp;
  logic signed [31:0]      s2_pi;
  logic signed [33:0]      s2_pd;

  logic signed [ERR_W-1:0] f_err1, f_err2;
  logic [DUTY_W-1:0]       f_duty;
  logic                    hit_s2, hit_wb1;
  logic signed [ERR_W:0]   d1;
  logic signed [ERR_W+1:0] d2;
  logic signed [32:0]      pp;
  logic signed [31:0]      pi;
  logic signed [33:0]      pd;

  assign hit_s2  = s2_valid && s2_ok && s1_ok && (s2_chan == s1_chan);
  assign hit_wb1 = wb_valid && s1_ok && (wb_chan == s1_chan);

  // Newest history first: item ahead (errors only), last write, memory.
  always_comb begin
    if (hit_s2) begin
      f_err1 = s2_err;
      f_err2 = s2_err1;
    end else if (hit_wb1) begin
      f_err1 = wb_err;
      f_err2 = wb_err1;
    end else if (rd_vld) begin
      f_err1 = rd_word.err_last;
      f_err2 = rd_word.err_prev;
    end else begin
      f_err1 = '0;
      f_err2 = '0;
    end
    if (hit_wb1) begin
      f_duty = wb_duty;
    end else if (rd_vld) begin
      f_duty = rd_word.duty;
    end else begin
      f_duty = '0;
    end
  end

  // First and second differences of the error.
  assign d1 = {s1_err[ERR_W-1], s1_err} - {f_err1[ERR_W-1], f_err1};
  assign d2 = {{2{s1_err[ERR_W-1]}}, s1_err} - {f_err1[ERR_W-1], f_err1, 1'b0}
            + {{2{f_err2[ERR_W-1]}}, f_err2};

  assign pp = gain_prop * d1;
  assign pi = gain_integ * s1_err;
  assign pd = gain_deriv * d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_chan <= s1_chan;
      s2_ok   <= s1_ok;
      s2_err  <= s1_err;
      s2_err1 <= f_err1;
      s2_duty <= f_duty;
      s2_pp   <= pp;
      s2_pi   <= pi;
      s2_pd   <= pd;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage: correction, duty update and clamp
  // --------------------------------------------------------------------------
  logic signed [SUMW-1:0] sum, sum_adj, sum_shr;
  logic signed [ERR_W-1:0] corr;
  logic [DUTY_W-1:0]       base_duty, new_duty;
  logic signed [DUTY_W+2:0] duty_sum;
  logic                    hit_wb2;

  assign sum     = s2_pp + s2_pi + s2_pd;
  // Truncate toward zero: bias negative sums before the arithmetic shift.
  assign sum_adj = sum + (sum[SUMW-1] ? RND_BIAS : '0);
  assign sum_shr = sum_adj >>> GAIN_FRAC_BITS;

  always_comb begin
    if (sum_shr > 36'sd32767) begin
      corr = 16'sh7FFF;
    end else if (sum_shr < -36'sd32768) begin
      corr = 16'sh8000;
    end else begin
      corr = sum_shr[ERR_W-1:0];
    end
  end

  // The write just made for the same channel supersedes the captured duty.
  assign hit_wb2   = wb_valid && s2_ok && (wb_chan == s2_chan);
  assign base_duty = hit_wb2 ? wb_duty : s2_duty;
  assign duty_sum  = {3'b000, base_duty} + {{2{corr[ERR_W-1]}}, corr};

  always_comb begin
    if (duty_sum[DUTY_W+2]) begin
      new_duty = '0;
    end else if (duty_sum[DUTY_W+1:0] > {2'b00, duty_max}) begin
      new_duty = duty_max;
    end else begin
      new_duty = duty_sum[DUTY_W-1:0];
    end
  end

  // State write-back as the item leaves for the output register.
  assign wr_en            = s2_valid && s2_ok && out_adv;
  assign wr_addr          = AW'(s2_chan);
  assign wr_word.err_last = s2_err;
  assign wr_word.err_prev = s2_err1;
  assign wr_word.duty     = new_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      wb_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_chan <= s2_chan;
      wb_err  <= s2_err;
      wb_err1 <= s2_err1;
      wb_duty <= new_duty;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s2_valid) begin
      out_channel <= s2_chan;
      duty        <= s2_ok ? new_duty : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid)
    else $error("accepted transaction did not reach the multiply stage");

  a_result_from_s2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result appeared without an item in the accumulate stage");

  a_write_gives_result: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && wb_valid))
    else $error("state write without a matching result");

  a_wb_entry_valid: assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> entry_valid[AW'(wb_chan)])
    else $error("last write names an entry not marked valid");

endmodule : incremental_pid_duty_controller_top

`default_nettype wire

// ===== tb/ipdc_duty_checker.sv =====
// ----------------------------------------------------------------------------
// ipdc_duty_checker: result checker for the incremental PID duty controller
// Watches the configuration, input and output channels of the block. Each
// accepted input transaction is run through a velocity-form PID predictor
// with its own gains and per-channel history, and the expected duty is
// queued. Each accepted output transaction is compared field by field with
// the oldest queued expectation. Counts are handed back to the testbench.
// ----------------------------------------------------------------------------

module ipdc_duty_checker #(
  parameter int CHANNELS       = ipdc_pkg::CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = ipdc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // Input channel
  input  wire logic                                    in_valid,
  input  wire logic                                    in_ready,
  input  wire logic                                    channel,
  input  wire logic signed [ipdc_pkg::SPEED_W-1:0]     target_speed,
  input  wire logic signed [ipdc_pkg::SPEED_W-1:0]     measured_speed,
  // Output channel
  input  wire logic                                    out_valid,
  input  wire logic                                    out_ready,
  input  wire logic                                    out_channel,
  input  wire logic        [ipdc_pkg::DUTY_W-1:0]      duty,
  // Configuration channel
  input  wire logic                                    cfg_valid,
  input  wire logic                                    cfg_ready,
  input  wire logic        [ipdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [ipdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Counts for the testbench
  output int                                           mismatches,
  output int                                           outstanding,
  output int                                           checked,
  output int                                           err_saturated,
  output int                                           clamped
);
  timeunit 1ns;
  timeprecision 1ps;

  import ipdc_pkg::*;

  // One expected output transaction.
  typedef struct packed {
    logic              chan;
    logic [DUTY_W-1:0] duty;
  } duty_result_t;

  duty_result_t duty_q [$];

  // Predictor copy of the registers and of every channel's history.
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic [DUTY_W-1:0]        dmax;
  state_word_t              chan_state [CHANNELS];

  int n_bad;
  int n_checked;
  int n_err_sat;
  int n_clamp;

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Works out the new duty of one channel and moves its history on.
  function automatic duty_result_t advance_channel(
    input logic                        chan,
    input logic signed [SPEED_W-1:0]   tgt,
    input logic signed [SPEED_W-1:0]   meas
  );
    longint       err;
    longint       err1;
    longint       err2;
    longint       corr;
    longint       acc;
    duty_result_t res;

    res.chan = chan;
    res.duty = '0;
    // A channel beyond the configured count leaves all state alone.
    if (int'(chan) >= CHANNELS) return res;

    err = longint'(tgt) - longint'(meas);
    if (err != clip16(err)) n_err_sat++;
    err  = clip16(err);
    err1 = longint'(chan_state[chan].err_last);
    err2 = longint'(chan_state[chan].err_prev);

    // Gain-weighted sum, fraction bits dropped toward zero, then saturated.
    corr = longint'(kp) * (err - err1) + longint'(ki) * err
         + longint'(kd) * (err - 2 * err1 + err2);
    corr = clip16(corr / (longint'(1) <<< GAIN_FRAC_BITS));

    // The kept duty plus the correction is held within 0..duty_max.
    acc = longint'(chan_state[chan].duty) + corr;
    if (acc < 0 || acc > longint'(dmax)) n_clamp++;
    if (acc < 0) acc = 0;
    if (acc > longint'(dmax)) acc = longint'(dmax);

    chan_state[chan].err_prev = chan_state[chan].err_last;
    chan_state[chan].err_last = err[ERR_W-1:0];
    chan_state[chan].duty     = acc[DUTY_W-1:0];
    res.duty                  = acc[DUTY_W-1:0];
    return res;
  endfunction

  // Follow the channels at every edge; counts leave through registers so the
  // testbench always reads the values from before the edge.
  always @(posedge clk) begin
    duty_result_t want;

    if (rst) begin
      kp   = GAIN_PROP_RST;
      ki   = GAIN_INTEG_RST;
      kd   = GAIN_DERIV_RST;
      dmax = DUTY_MAX_RST;
      foreach (chan_state[i]) chan_state[i] = '0;
      duty_q.delete();
    end else begin
      // Register writes; an index outside the map changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_PROP:  kp = cfg_data;
          REG_GAIN_INTEG: ki = cfg_data;
          REG_GAIN_DERIV: kd = cfg_data;
          REG_DUTY_MAX:   dmax = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        duty_q.push_back(advance_channel(channel, target_speed, measured_speed));

      // Compare each result transaction with the oldest expectation.
      if (out_valid && out_ready) begin
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got channel %0d duty %0d",
                   $time, out_channel, duty);
          n_bad++;
        end else begin
          want = duty_q.pop_front();
          n_checked++;
          if (out_channel !== want.chan) begin
            $display("%0t: out_channel mismatch, expected %0d, got %0d",
                     $time, want.chan, out_channel);
            n_bad++;
          end
          if (duty !== want.duty) begin
            $display("%0t: duty mismatch on channel %0d, expected %0d, got %0d",
                     $time, want.chan, want.duty, duty);
            n_bad++;
          end
        end
      end
    end

    mismatches    <= n_bad;
    outstanding   <= duty_q.size();
    checked       <= n_checked;
    err_saturated <= n_err_sat;
    clamped       <= n_clamp;
  end

endmodule : ipdc_duty_checker

// ===== tb/tb_incremental_pid_duty_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_incremental_pid_duty_controller_top: testbench of the PID duty controller
// Drives speed transactions and register writes into the block with random
// gaps on both sides, a long output stall and pauses for the pipeline to
// empty. A directed opening covers error saturation, correction saturation,
// truncation toward zero, the duty clamps and an unmapped register index;
// the random rounds then mix steady tracking with noise and field extremes
// under several gain settings. The checker module judges every result.
// ----------------------------------------------------------------------------

module tb_incremental_pid_duty_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipdc_pkg::*;

  localparam int ROUNDS          = 10;
  localparam int ITEMS_PER_ROUND = 110;
  localparam int LONG_HOLD       = 40;
  localparam int DRAIN_SLACK     = 4;
  localparam int CYCLE_LIMIT     = 200000;

  // An index with no register behind it.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd9;

  logic                        clk;
  logic                        rst            = 1'b1;
  logic                        in_valid       = 1'b0;
  logic                        channel        = 1'b0;
  logic signed [SPEED_W-1:0]   target_speed   = '0;
  logic signed [SPEED_W-1:0]   measured_speed = '0;
  logic                        out_ready      = 1'b0;
  logic                        cfg_valid      = 1'b0;
  logic [CFG_INDEX_W-1:0]      cfg_index      = REG_GAIN_PROP;
  logic [CFG_DATA_W-1:0]       cfg_data       = '0;
  wire logic                   in_ready;
  wire logic                   out_valid;
  wire logic                   out_channel;
  wire logic [DUTY_W-1:0]      duty;
  wire logic                   cfg_ready;

  int mismatches;
  int outstanding;
  int checked;
  int err_saturated;
  int clamped;

  int cycles   = 0;
  int settings = 0;
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit rx_hold  = 1'b0;

  incremental_pid_duty_controller_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .duty           (duty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  ipdc_duty_checker u_duty_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .duty           (duty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked        (checked),
    .err_saturated  (err_saturated),
    .clamped        (clamped)
  );

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending", cycles, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: a random stall before each transaction, and on request one
  // long hold-off so that the pipeline fills and the input stalls.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = rx_gaps ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one speed transaction and returns at the edge that accepts it,
  // with valid still high so that a following item can go back to back.
  task automatic send_item(input logic chan, input logic signed [SPEED_W-1:0] tgt,
                           input logic signed [SPEED_W-1:0] meas);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    channel        <= chan;
    target_speed   <= tgt;
    measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering items and waits until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // One register write; valid stays high for a write that follows directly.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                              input logic [CFG_DATA_W-1:0] kd,
                              input logic [CFG_DATA_W-1:0] dmax);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_DUTY_MAX, dmax);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [SPEED_W-1:0] extreme_speed();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] extreme_gain();
    return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
  endfunction

  // Stimulus and verdict.
  initial begin
    int                        round;
    int                        n;
    int                        kind;
    logic                      chan;
    logic signed [SPEED_W-1:0] tgt;
    logic signed [SPEED_W-1:0] meas;
    logic [CFG_DATA_W-1:0]     kp;
    logic [CFG_DATA_W-1:0]     ki;
    logic [CFG_DATA_W-1:0]     kd;
    logic [CFG_DATA_W-1:0]     dmax;
    logic signed [SPEED_W-1:0] setpoint [2];

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset gains: zero error, a step, both error saturations, equal extremes.
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd100, 16'sd0);
    send_item(1'b1, -16'sd32768, 16'sd32767);
    send_item(1'b1, 16'sd32767, -16'sd32768);
    send_item(1'b0, 16'sd32767, 16'sd32767);
    send_item(1'b0, -16'sd32768, -16'sd32768);
    send_item(1'b1, -16'sd1, 16'sd0);
    drain();

    // Extreme gains drive the correction into saturation both ways; the duty
    // limit write carries a top bit that must be ignored, and a write to an
    // unmapped index must change nothing.
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    program_regs(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_item(1'b0, 16'sd32767, -16'sd32768);
    send_item(1'b0, -16'sd32768, 16'sd32767);
    send_item(1'b1, 16'sd32767, -16'sd32768);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd0, 16'sd0);
    drain();

    // A tiny integral gain: negative sums below one whole step truncate to 0.
    program_regs(16'd0, 16'd1, 16'd0, 16'h7FFF);
    send_item(1'b0, 16'sd32767, -16'sd32768);
    send_item(1'b1, 16'sd32767, -16'sd32768);
    send_item(1'b0, -16'sd1, 16'sd0);
    send_item(1'b0, -16'sd255, 16'sd0);
    send_item(1'b0, 16'sd255, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd256);
    drain();

    // Lowering the duty limit pulls both kept duties down with no correction.
    program_regs(16'd0, 16'd0, 16'd0, 16'd7);
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd0);

    // Random rounds, each under its own register setting and idling pattern.
    for (round = 0; round < ROUNDS; round++) begin
      drain();
      case (round % 5)
        0: begin
          kp = GAIN_PROP_RST;
          ki = GAIN_INTEG_RST;
          kd = GAIN_DERIV_RST;
          dmax = 16'(DUTY_MAX_RST);
        end
        1: begin
          kp = extreme_gain();
          ki = extreme_gain();
          kd = extreme_gain();
          dmax = (round < 5) ? 16'h0000 : 16'hFFFF;
        end
        2: begin
          kp = CFG_DATA_W'($urandom);
          ki = CFG_DATA_W'($urandom);
          kd = CFG_DATA_W'($urandom);
          dmax = CFG_DATA_W'($urandom);
        end
        default: begin
          kp = CFG_DATA_W'($urandom_range(0, 3072));
          ki = CFG_DATA_W'($urandom_range(0, 768));
          kd = CFG_DATA_W'($urandom_range(0, 256));
          if ($urandom_range(0, 3) == 0) kd = -kd;
          dmax = CFG_DATA_W'($urandom_range(20, 2000));
        end
      endcase
      program_regs(kp, ki, kd, dmax);

      tx_gaps = (round % 4 == 0) || (round % 4 == 2);
      rx_gaps = (round % 4 == 0) || (round % 4 == 3);
      if (round == 3) rx_hold = 1'b1;
      setpoint[0] = SPEED_W'(int'($urandom_range(0, 8000)) - 4000);
      setpoint[1] = SPEED_W'(int'($urandom_range(0, 8000)) - 4000);

      // Mostly steady tracking near a setpoint, with noise and extremes mixed in.
      for (n = 0; n < ITEMS_PER_ROUND; n++) begin
        kind = $urandom_range(0, 9);
        chan = 1'($urandom_range(0, 1));
        if (kind == 0) begin
          tgt  = SPEED_W'($urandom);
          meas = SPEED_W'($urandom);
        end else if (kind == 1) begin
          tgt  = extreme_speed();
          meas = extreme_speed();
        end else begin
          if ($urandom_range(0, 19) == 0)
            setpoint[chan] = SPEED_W'(int'($urandom_range(0, 8000)) - 4000);
          tgt  = setpoint[chan];
          meas = SPEED_W'(int'(setpoint[chan]) + int'($urandom_range(0, 200)) - 100);
        end
        send_item(chan, tgt, meas);
      end
    end
    drain();

    $display("Covered %0d duty results under %0d register settings, with random gaps,",
             checked, settings);
    $display("a long output stall and drains; %0d error saturations, %0d duty clamps.",
             err_saturated, clamped);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : tb_incremental_pid_duty_controller_top

// ===== incremental_pid_duty_controller_top.f =====
hw/rtl/ipdc_pkg.sv
hw/rtl/ipdc_ram.sv
hw/rtl/incremental_pid_duty_controller_top.sv
tb/ipdc_duty_checker.sv
tb/tb_incremental_pid_duty_controller_top.sv
